FILE: rtl/core/mh64_pkg.sv
// shared types, constants and helpers for the 64-bit murmur byte stream hash
package mh64_pkg;

  localparam logic [31:0] MUL_LO    = 32'h5bd1e995;
  localparam logic [31:0] MUL_HI    = 32'hc6a4a793;
  localparam int          MIX_SHIFT = 47;
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  // work queue between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int LVL_W  = $clog2(QDEPTH + 1);

  // word kinds decided by the front
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_TAIL = 2'd1;
  localparam logic [1:0] OP_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] word;
    logic        first;
    logic        last;
    logic [31:0] len;
  } entry_t;

  function automatic logic [63:0] shift_mix(input logic [63:0] v);
    shift_mix = v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

FILE: rtl/core/mh64_if.sv
// stream interfaces for message words and finished hashes
interface mh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        first_word;
  logic        last_word;
  logic [31:0] total_length;

  modport source(output valid, data_word, valid_bytes, first_word, last_word, total_length,
                 input ready);
  modport sink(input valid, data_word, valid_bytes, first_word, last_word, total_length,
               output ready);
endinterface

interface mh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

FILE: rtl/core/mh64_front.sv
// front end: takes message beats, classifies them and masks tails
module mh64_front (
  mh64_in_if.sink          msg,
  output logic             push_valid,
  input  logic             push_ready,
  output mh64_pkg::entry_t push_data
);

  logic [63:0] masked;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < msg.valid_bytes) ? msg.data_word[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    push_data.word  = masked;
    push_data.first = msg.first_word;
    push_data.last  = msg.last_word;
    push_data.len   = msg.total_length;
    // eight and above counts as a full word
    if (msg.valid_bytes >= mh64_pkg::FULL_BYTES) begin
      push_data.op   = mh64_pkg::OP_FULL;
      push_data.word = msg.data_word;
    end else if (msg.valid_bytes != 4'd0) begin
      push_data.op = mh64_pkg::OP_TAIL;
    end else begin
      push_data.op = mh64_pkg::OP_NONE;
    end
  end

  assign push_valid = msg.valid;
  assign msg.ready  = push_ready;

endmodule

FILE: rtl/core/mh64_queue.sv
// short fifo of classified words between front and back
module mh64_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  mh64_pkg::entry_t             push_data,
  output logic                         pop_valid,
  input  logic                         pop_ready,
  output mh64_pkg::entry_t             pop_data,
  output logic [mh64_pkg::LVL_W-1:0]   level
);

  mh64_pkg::entry_t                 slots [mh64_pkg::QDEPTH];
  logic [mh64_pkg::PTR_W-1:0]       wptr;
  logic [mh64_pkg::PTR_W-1:0]       rptr;
  logic                             do_push;
  logic                             do_pop;

  localparam logic [mh64_pkg::PTR_W-1:0] LAST_PTR = mh64_pkg::PTR_W'(mh64_pkg::QDEPTH - 1);
  localparam logic [mh64_pkg::LVL_W-1:0] FULL_LVL = mh64_pkg::LVL_W'(mh64_pkg::QDEPTH);

  assign push_ready = (level != FULL_LVL);
  assign pop_valid  = (level != '0);
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mh64_back.sv
// back end: hash sequencer around one shared 32x32 multiplier, with output register
module mh64_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      seed,
  input  logic             q_valid,
  output logic             q_ready,
  input  mh64_pkg::entry_t q_data,
  mh64_out_if.source       digest
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_KEY1 = 3'd2;
  localparam logic [2:0] ST_KEY2 = 3'd3;
  localparam logic [2:0] ST_HASH = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;

  logic [2:0]       state, state_next;
  logic [1:0]       ph, ph_next;
  logic [63:0]      acc, acc_next;
  logic [63:0]      opa, opa_next;
  logic [63:0]      hash, hash_next;
  mh64_pkg::entry_t cur, cur_next;
  logic             res_valid, res_valid_next;
  logic [63:0]      res_data, res_data_next;

  logic [31:0] a_part;
  logic [31:0] m_part;
  logic [63:0] prod;
  logic [63:0] mres;
  logic        adv;

  // low 64 bits of opa * M from three 32-bit partial products
  assign a_part = (ph == PH_HL) ? opa[63:32] : opa[31:0];
  assign m_part = (ph == PH_LH) ? mh64_pkg::MUL_HI : mh64_pkg::MUL_LO;
  assign prod   = 64'(a_part) * 64'(m_part);
  assign mres   = acc + {prod[31:0], 32'h0};

  // finishing waits while the previous hash is still unread
  assign adv = !((state == ST_FIN) && (ph == PH_HL) && res_valid && !digest.ready);

  assign q_ready          = (state == ST_IDLE);
  assign digest.valid      = res_valid;
  assign digest.hash_value = res_data;

  always_comb begin
    mh64_pkg::entry_t e;
    logic [63:0]      hv;
    logic             disp;

    state_next     = state;
    ph_next        = ph;
    acc_next       = acc;
    opa_next       = opa;
    hash_next      = hash;
    cur_next       = cur;
    res_valid_next = res_valid;
    res_data_next  = res_data;
    e              = cur;
    hv             = hash;
    disp           = 1'b0;

    if (res_valid && digest.ready) begin
      res_valid_next = 1'b0;
    end

    if (state == ST_IDLE) begin
      if (q_valid) begin
        cur_next = q_data;
        ph_next  = PH_LL;
        if (q_data.first) begin
          state_next = ST_LEN;
          opa_next   = {32'h0, q_data.len};
        end else begin
          disp = 1'b1;
          e    = q_data;
          hv   = hash;
        end
      end
    end else if (adv) begin
      if (ph != PH_HL) begin
        ph_next  = ph + 1'b1;
        acc_next = (ph == PH_LL) ? prod : mres;
      end else begin
        ph_next = PH_LL;
        unique case (state)
          ST_LEN: begin
            disp = 1'b1;
            hv   = seed ^ mres;
          end
          ST_KEY1: begin
            state_next = ST_KEY2;
            opa_next   = mh64_pkg::shift_mix(mres);
          end
          ST_KEY2: begin
            state_next = ST_HASH;
            opa_next   = hash ^ mres;
          end
          ST_HASH: begin
            hash_next = mres;
            if (cur.last) begin
              state_next = ST_FIN;
              opa_next   = mh64_pkg::shift_mix(mres);
            end else begin
              state_next = ST_IDLE;
            end
          end
          ST_FIN: begin
            res_valid_next = 1'b1;
            res_data_next  = mh64_pkg::shift_mix(mres);
            state_next     = ST_IDLE;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
    end

    // start the mixing of a word once its starting hash is known
    if (disp) begin
      hash_next = hv;
      unique case (e.op)
        mh64_pkg::OP_FULL: begin
          state_next = ST_KEY1;
          opa_next   = e.word;
        end
        mh64_pkg::OP_TAIL: begin
          state_next = ST_HASH;
          opa_next   = hv ^ e.word;
        end
        default: begin
          if (e.last) begin
            state_next = ST_FIN;
            opa_next   = mh64_pkg::shift_mix(hv);
          end else begin
            state_next = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= PH_LL;
      hash      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ph        <= ph_next;
      hash      <= hash_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    acc      <= acc_next;
    opa      <= opa_next;
    cur      <= cur_next;
    res_data <= res_data_next;
  end

endmodule

FILE: rtl/core/murmur64_byte_stream_hash.sv
// top level of the 64-bit murmur byte stream hash
//
//  port       kind         moves
//  msg        stream in    one message word per beat, length on the first
//  digest     stream out   one finished 64-bit hash per last word
//  seed_*     write only   seed register, taken on any edge with seed_we high
//
// a word is dispatched, then each 64-bit multiply runs as partial products on
// the single 32x32 multiplier: one multiply for the length on a first word,
// three for a full word, one for a tail and one for the finish on a last word
// reset clears seed, running hash, queue and output valid; no sweep
// a two-beat queue lets msg keep flowing while the sequencer works or the
// digest register waits to be taken
module murmur64_byte_stream_hash (
  input  logic        clk,
  input  logic        rst,
  mh64_in_if.sink     msg,
  mh64_out_if.source  digest,
  input  logic        seed_we,
  input  logic [63:0] seed_data
);

  logic [63:0]                    hash_seed;
  logic                           push_valid;
  logic                           push_ready;
  mh64_pkg::entry_t               push_data;
  logic                           pop_valid;
  logic                           pop_ready;
  mh64_pkg::entry_t               pop_data;
  logic [mh64_pkg::LVL_W-1:0]     q_level;
  logic                           q_push;
  logic                           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (seed_we) begin
      hash_seed <= seed_data;
    end
  end

  mh64_front u_front (
    .msg        (msg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mh64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .level      (q_level)
  );

  mh64_back u_back (
    .clk     (clk),
    .rst     (rst),
    .seed    (hash_seed),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .digest  (digest)
  );

  assign q_push = push_valid && push_ready;
  assign q_pop  = pop_valid && pop_ready;

  // a full queue must hold the input off
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (q_level == mh64_pkg::LVL_W'(mh64_pkg::QDEPTH)) |-> !msg.ready)
    else $error("beat taken while queue full");

  // queue level tracks push without pop
  a_level_up: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (q_level == $past(q_level) + 1'b1))
    else $error("queue level did not rise on push");

  a_level_down: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_push) |=> (q_level == $past(q_level) - 1'b1))
    else $error("queue level did not fall on pop");

  // no result survives reset
  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !digest.valid)
    else $error("digest valid right after reset");

endmodule

FILE: test/murmur64_byte_stream_hash_test.sv
// self-checking testbench for the 64-bit murmur byte stream hash
module murmur64_byte_stream_hash_test;

  localparam logic [63:0] MURMUR_M = {mh64_pkg::MUL_HI, mh64_pkg::MUL_LO};
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT = 4000;
  localparam int MAX_GAP = 24;

  logic        clk = 1'b0;
  logic        rst;
  logic        seed_we;
  logic [63:0] seed_data;

  mh64_in_if  msg_if();
  mh64_out_if digest_if();

  murmur64_byte_stream_hash DUT (
    .clk(clk),
    .rst(rst),
    .msg(msg_if),
    .digest(digest_if),
    .seed_we(seed_we),
    .seed_data(seed_data)
  );

  // predictor state
  logic [63:0] model_seed;
  logic [63:0] chain_hash;
  logic [63:0] expected_digests[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int words_sent;
  int messages_sent;
  int digests_checked;
  int seeds_used;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("run timed out");
    $display("** murmur64_byte_stream_hash: FAILED **");
    $finish;
  end

  function automatic logic [63:0] fold47(input logic [63:0] v);
    return v ^ (v >> mh64_pkg::MIX_SHIFT);
  endfunction

  function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [63:0] word,
                                             input logic [3:0] nbytes);
    logic [63:0] k;
    logic [63:0] mask;
    if (nbytes >= mh64_pkg::FULL_BYTES) begin
      k = fold47(word * MURMUR_M) * MURMUR_M;
      return (h ^ k) * MURMUR_M;
    end else if (nbytes != 4'd0) begin
      mask = ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * nbytes));
      return (h ^ (word & mask)) * MURMUR_M;
    end
    return h;
  endfunction

  function automatic logic [63:0] finish_hash(input logic [63:0] h);
    return fold47(fold47(h) * MURMUR_M);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    digest_if.ready = rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each digest beat with the oldest prediction
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && digest_if.valid && digest_if.ready) begin
      if (expected_digests.size() == 0) begin
        if (error_count < 10)
          $display("unexpected digest %h", digest_if.hash_value);
        error_count++;
      end else begin
        want = expected_digests.pop_front();
        digests_checked++;
        if (digest_if.hash_value !== want) begin
          if (error_count < 10)
            $display("digest mismatch: expected %h got %h", want, digest_if.hash_value);
          error_count++;
        end
      end
    end
  end

  // sends one word beat, called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [63:0] word, input logic [3:0] nbytes,
                           input logic first, input logic last, input logic [31:0] len);
    int gap;
    logic [63:0] start;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      msg_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_if.valid = 1'b1;
    msg_if.data_word = word;
    msg_if.valid_bytes = nbytes;
    msg_if.first_word = first;
    msg_if.last_word = last;
    msg_if.total_length = len;
    do @(posedge clk); while (!msg_if.ready);
    start = first ? (model_seed ^ ({32'd0, len} * MURMUR_M)) : chain_hash;
    chain_hash = absorb_word(start, word, nbytes);
    if (last)
      expected_digests.push_back(finish_hash(chain_hash));
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // a message of nbytes_total bytes, optionally without its first or last mark
  task automatic send_message(input int nbytes_total, input logic [31:0] len_field,
                              input bit with_first, input bit with_last);
    int words;
    int rest;
    logic [3:0] nb;
    words = (nbytes_total == 0) ? 1 : (nbytes_total + 7) / 8;
    for (int i = 0; i < words; i++) begin
      rest = nbytes_total - 8 * i;
      nb = (rest >= 8) ? mh64_pkg::FULL_BYTES : rest[3:0];
      send_word(rand_word(), nb, with_first && (i == 0), with_last && (i == words - 1),
                len_field);
    end
  endtask

  // lets everything finish so the seed can be changed safely
  task automatic drain_digests();
    int waited;
    msg_if.valid = 1'b0;
    waited = 0;
    while (expected_digests.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_digests.size() != 0) begin
      $display("%0d expected digests never arrived", expected_digests.size());
      error_count += expected_digests.size();
      expected_digests.delete();
    end
  endtask

  task automatic write_seed(input logic [63:0] value);
    seed_we = 1'b1;
    seed_data = value;
    @(negedge clk);
    seed_we = 1'b0;
    model_seed = value;
    seeds_used++;
  endtask

  task automatic test_directed_cases();
    logic [63:0] w;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // no first mark straight after reset: carries on from a cleared hash
    send_word(64'h0123_4567_89ab_cdef, mh64_pkg::FULL_BYTES, 1'b0, 1'b1, 32'd0);
    // empty message
    send_word(rand_word(), 4'd0, 1'b1, 1'b1, 32'd0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, mh64_pkg::FULL_BYTES, 1'b1, 1'b1, 32'd8);
    send_word(64'h0, mh64_pkg::FULL_BYTES, 1'b1, 1'b1, 32'd8);
    // tails of every size, upper bytes set to show masking
    for (int n = 1; n < 8; n++)
      send_word(64'hFFFF_FFFF_FFFF_FFFF, n[3:0], 1'b1, 1'b1, 32'(n));
    // oversized byte counts with a length that does not match
    send_word(rand_word(), 4'd9, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_word(rand_word(), 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // short word that is not last, then more words
    w = rand_word();
    send_word(w, 4'd3, 1'b1, 1'b0, 32'd11);
    send_word(rand_word(), mh64_pkg::FULL_BYTES, 1'b0, 1'b1, 32'd11);
    // continues from the unfinished hash of the previous message
    send_word(rand_word(), mh64_pkg::FULL_BYTES, 1'b0, 1'b1, 32'd0);
    // empty word in the middle of a message
    send_word(rand_word(), mh64_pkg::FULL_BYTES, 1'b1, 1'b0, 32'd16);
    send_word(rand_word(), 4'd0, 1'b0, 1'b0, 32'd16);
    send_word(rand_word(), mh64_pkg::FULL_BYTES, 1'b0, 1'b1, 32'd16);
    drain_digests();
  endtask

  task automatic test_seed_extremes();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_message(21, 32'd21, 1'b1, 1'b1);
    send_message(0, 32'd0, 1'b1, 1'b1);
    send_message(8, 32'hFFFF_FFFF, 1'b1, 1'b1);
    drain_digests();
    write_seed(64'h8000_0000_0000_0001);
    send_message(13, 32'd13, 1'b1, 1'b1);
    drain_digests();
    write_seed(64'h0);
    send_message(16, 32'd16, 1'b1, 1'b1);
    drain_digests();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
    int start_words;
    int pick;
    int nbytes_total;
    logic [31:0] len_field;
    write_seed(rand_word());
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_words = words_sent;
    while (words_sent - start_words < target) begin
      pick = $urandom_range(99);
      nbytes_total = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
      len_field = ($urandom_range(9) == 0) ? $urandom : 32'(nbytes_total);
      if (pick < 80) begin
        send_message(nbytes_total, len_field, 1'b1, 1'b1);
        messages_sent++;
      end else if (pick < 90) begin
        // broken message: lose either the first or the last mark
        if ($urandom_range(1) == 0)
          send_message(nbytes_total, len_field, 1'b0, 1'b1);
        else
          send_message(nbytes_total, len_field, 1'b1, 1'b0);
      end else begin
        send_word(rand_word(), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom);
      end
    end
    drain_digests();
  endtask

  initial begin
    rst = 1'b1;
    seed_we = 1'b0;
    seed_data = 64'h0;
    msg_if.valid = 1'b0;
    msg_if.data_word = 64'h0;
    msg_if.valid_bytes = 4'd0;
    msg_if.first_word = 1'b0;
    msg_if.last_word = 1'b0;
    msg_if.total_length = 32'd0;
    model_seed = 64'h0;
    chain_hash = 64'h0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    error_count = 0;
    words_sent = 0;
    messages_sent = 0;
    digests_checked = 0;
    seeds_used = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_seed_extremes();
    test_random_traffic(34, 46, 140);
    test_random_traffic(46, 34, 140);
    test_random_traffic(0, 0, 140);

    $display("sent %0d word beats, %0d random well-formed messages plus broken and noise beats",
             words_sent, messages_sent);
    $display("checked %0d digests across %0d seed writes", digests_checked, seeds_used);
    if (error_count == 0)
      $display("** murmur64_byte_stream_hash: PASSED **");
    else
      $display("** murmur64_byte_stream_hash: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mh64_pkg.sv
rtl/core/mh64_if.sv
rtl/core/mh64_front.sv
rtl/core/mh64_queue.sv
rtl/core/mh64_back.sv
rtl/core/murmur64_byte_stream_hash.sv
test/murmur64_byte_stream_hash_test.sv
